@@ rtl/core/fss_pkg.sv @@
// fss_pkg: shared types and constants of the frame sequence stepper
// request codes, register indexes, controller states and the command and status structs
// no dependencies
package fss_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic REG_TICK_PERIOD = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  localparam int unsigned TICK_PERIOD_RESET = 256;
  localparam int unsigned FRAME_COUNT_RESET = 1;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_FWD  = 2'd1;
  localparam logic [1:0] REQ_BWD  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX,
    ST_DONE
  } fss_state_e;

  typedef struct packed {
    logic start;
    logic iter;
    logic fix;
    logic sel_last;
    logic out_load;
  } fss_cmd_t;

  typedef struct packed {
    logic need_iter;
    logic need_fix;
  } fss_status_t;

endpackage

@@ rtl/core/fss_regs.sv @@
// fss_regs: configuration registers behind the apb-style port
// holds tick period and frame count; depends on fss_pkg
module fss_regs #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned TIME_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [fss_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [fss_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [fss_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready,
  output logic [TIME_BITS-1:0]                   tick_period_o,
  output logic [$clog2(MAX_FRAMES+1)-1:0]        frame_count_o
);
  import fss_pkg::*;

  localparam int unsigned COUNT_W = $clog2(MAX_FRAMES + 1);

  logic [TIME_BITS-1:0] tick_period_q;
  logic [COUNT_W-1:0]   frame_count_q;
  logic                 reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TIME_BITS'(TICK_PERIOD_RESET);
      frame_count_q <= COUNT_W'(FRAME_COUNT_RESET);
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK_PERIOD: tick_period_q <= pwdata[TIME_BITS-1:0];
        REG_FRAME_COUNT: frame_count_q <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TICK_PERIOD: prdata = APB_DATA_W'(tick_period_q);
      REG_FRAME_COUNT: prdata = APB_DATA_W'(frame_count_q);
      default:         prdata = '0;
    endcase
  end

  assign tick_period_o = tick_period_q;
  assign frame_count_o = frame_count_q;

endmodule

@@ rtl/core/fss_ctrl.sv @@
// fss_ctrl: controller state machine of the frame sequence stepper
// sequences accept, period spending, end fixup and result handoff; depends on fss_pkg
module fss_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  fss_pkg::fss_status_t status_i,
  output fss_pkg::fss_cmd_t    cmd_o
);
  import fss_pkg::*;

  fss_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.need_iter) begin
          if (status_i.need_fix) state_d = ST_FIX;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FIX: state_d = ST_RUN;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: cmd_o.start = in_valid_i;
      ST_RUN: begin
        if (status_i.need_iter) begin
          cmd_o.iter     = !status_i.need_fix;
          cmd_o.sel_last = status_i.need_fix;
        end else begin
          cmd_o.out_load = out_free;
        end
      end
      ST_FIX:  cmd_o.fix = 1'b1;
      ST_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a waiting word");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.iter, cmd_o.fix, cmd_o.out_load}))
    else $error("more than one datapath command");

  a_fix_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fix |=> (state_q == ST_RUN))
    else $error("fixup not followed by run");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_RUN && !out_valid_o) || (state_q == ST_RUN))
    else $error("accepted word did not start a run");
`endif

endmodule

@@ rtl/core/fss_dp.sv @@
// fss_dp: datapath of the frame sequence stepper
// time accumulator, playback position, frame length table and result register; depends on fss_pkg
module fss_dp #(
  parameter int unsigned MAX_FRAMES  = 16,
  parameter int unsigned LENGTH_BITS = 8,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fss_pkg::fss_cmd_t                 cmd_i,
  output fss_pkg::fss_status_t              status_o,
  input  logic [TIME_BITS-1:0]              tick_period_i,
  input  logic [$clog2(MAX_FRAMES+1)-1:0]   frame_count_i,
  input  logic [1:0]                        req_type_i,
  input  logic [TIME_BITS-1:0]              elapsed_time_i,
  input  logic                              wrap_enable_i,
  input  logic [$clog2(MAX_FRAMES)-1:0]     entry_index_i,
  input  logic [LENGTH_BITS-1:0]            entry_length_i,
  output logic                              finished_o,
  output logic [$clog2(MAX_FRAMES)-1:0]     frame_now_o,
  output logic [LENGTH_BITS-1:0]            subtick_now_o
);
  import fss_pkg::*;

  localparam int unsigned FRAME_W = $clog2(MAX_FRAMES);
  localparam int unsigned COUNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_W   = FRAME_W + 1;
  localparam int unsigned ACC_W   = TIME_BITS + 2;

  logic [LENGTH_BITS-1:0] len_mem [MAX_FRAMES];

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [FRAME_W-1:0]      frame_q, frame_d;
  logic [LENGTH_BITS-1:0]  sub_q, sub_d;
  logic                    fin_q, fin_d;
  logic                    step_q, step_d;
  logic                    fwd_q, fwd_d;
  logic                    wrap_q, wrap_d;

  logic [TIME_BITS-1:0]    per_eff;
  logic signed [ACC_W-1:0] per_s;
  logic signed [ACC_W-1:0] el_s;
  logic [COUNT_W-1:0]      cnt_eff;
  logic [FRAME_W-1:0]      last_frame;
  logic [FRAME_W-1:0]      rd_addr;
  logic [LENGTH_BITS-1:0]  rd_len_q;
  logic [LENGTH_BITS-1:0]  len_m1;
  logic [CMP_W-1:0]        frame_inc;
  logic                    frame_wraps;
  logic                    at_fwd_end;
  logic                    at_bwd_end;
  logic                    load_ok;

  assign per_eff = (tick_period_i == '0) ? TIME_BITS'(1) : tick_period_i;
  assign per_s   = $signed({2'b00, per_eff});
  assign el_s    = $signed({2'b00, elapsed_time_i});

  always_comb begin
    if (frame_count_i == '0) begin
      cnt_eff = COUNT_W'(1);
    end else if (frame_count_i > COUNT_W'(MAX_FRAMES)) begin
      cnt_eff = COUNT_W'(MAX_FRAMES);
    end else begin
      cnt_eff = frame_count_i;
    end
  end

  assign last_frame = FRAME_W'(cnt_eff - COUNT_W'(1));

  // table read for the next cycle: last frame ahead of a fixup, else current or previous frame
  always_comb begin
    if (cmd_i.sel_last) begin
      rd_addr = last_frame;
    end else if (fwd_d) begin
      rd_addr = frame_d;
    end else begin
      rd_addr = frame_d - FRAME_W'(1);
    end
  end

  assign len_m1      = (rd_len_q == '0) ? '0 : rd_len_q - LENGTH_BITS'(1);
  assign frame_inc   = CMP_W'(frame_q) + CMP_W'(1);
  assign frame_wraps = frame_inc >= CMP_W'(cnt_eff);
  assign at_fwd_end  = (sub_q >= rd_len_q) && frame_wraps;
  assign at_bwd_end  = (sub_q == '0) && (frame_q == '0);

  assign status_o.need_iter = step_q && (fwd_q ? (acc_q > per_s) : acc_q[ACC_W-1]);
  assign status_o.need_fix  = fwd_q ? (at_fwd_end && !wrap_q) : (at_bwd_end && wrap_q);

  assign load_ok = (CMP_W'(entry_index_i) < CMP_W'(MAX_FRAMES));

  always_comb begin
    acc_d   = acc_q;
    frame_d = frame_q;
    sub_d   = sub_q;
    fin_d   = fin_q;
    step_d  = step_q;
    fwd_d   = fwd_q;
    wrap_d  = wrap_q;
    if (cmd_i.start) begin
      fin_d  = 1'b0;
      step_d = (req_type_i == REQ_FWD) || (req_type_i == REQ_BWD);
      fwd_d  = (req_type_i == REQ_FWD);
      wrap_d = wrap_enable_i;
      case (req_type_i)
        REQ_FWD: acc_d = acc_q + el_s;
        REQ_BWD: acc_d = acc_q - el_s;
        default: ;
      endcase
    end else if (cmd_i.iter) begin
      if (fwd_q) begin
        acc_d = acc_q - per_s;
        if (sub_q >= rd_len_q) begin
          sub_d = '0;
          if (frame_wraps) begin
            fin_d   = 1'b1;
            frame_d = '0;
          end else begin
            frame_d = frame_inc[FRAME_W-1:0];
          end
        end else begin
          sub_d = sub_q + LENGTH_BITS'(1);
        end
      end else begin
        acc_d = acc_q + per_s;
        if (sub_q != '0) begin
          sub_d = sub_q - LENGTH_BITS'(1);
        end else if (frame_q == '0) begin
          // hold at the start of the sequence
          fin_d = 1'b1;
          acc_d = per_s;
        end else begin
          frame_d = frame_q - FRAME_W'(1);
          sub_d   = rd_len_q;
        end
      end
    end else if (cmd_i.fix) begin
      fin_d   = 1'b1;
      frame_d = last_frame;
      sub_d   = len_m1;
      acc_d   = fwd_q ? '0 : acc_q + per_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      frame_q <= '0;
      sub_q   <= '0;
      fin_q   <= 1'b0;
      step_q  <= 1'b0;
      fwd_q   <= 1'b0;
      wrap_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      frame_q <= frame_d;
      sub_q   <= sub_d;
      fin_q   <= fin_d;
      step_q  <= step_d;
      fwd_q   <= fwd_d;
      wrap_q  <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && (req_type_i == REQ_LOAD) && load_ok) begin
      len_mem[entry_index_i] <= entry_length_i;
    end
    rd_len_q <= len_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      finished_o    <= fin_q;
      frame_now_o   <= frame_q;
      subtick_now_o <= sub_q;
    end
  end

endmodule

@@ rtl/core/frame_sequence_stepper_top.sv @@
// frame_sequence_stepper_top: top level of the frame sequence stepper
// joins fss_regs, fss_ctrl and fss_dp; depends on fss_pkg
//
//   channel   handshake                 payload
//   in        in_valid_i / in_stall_o   req_type, elapsed_time, wrap_enable, entry_index,
//                                       entry_length
//   out       out_valid_o / out_stall_i finished, frame_now, subtick_now
//   config    psel/penable/pwrite/pready tick_period at 0x0, frame_count at 0x4
//
// a load word is handed to the result register without spending tick periods; a step word
// first spends its tick periods, one per cycle, and for each end crossing that needs the last
// frame's length reads that length and runs a fixup state before its result is loaded
// reset clears position, accumulator and the output valid; the length table is not cleared
// input is stalled from accept until the result sits in the output register, which a
// stalled output word holds while the next word is already accepted
module frame_sequence_stepper_top #(
  parameter int unsigned MAX_FRAMES  = 16,
  parameter int unsigned LENGTH_BITS = 8,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic [TIME_BITS-1:0]              elapsed_time_i,
  input  logic                              wrap_enable_i,
  input  logic [$clog2(MAX_FRAMES)-1:0]     entry_index_i,
  input  logic [LENGTH_BITS-1:0]            entry_length_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              finished_o,
  output logic [$clog2(MAX_FRAMES)-1:0]     frame_now_o,
  output logic [LENGTH_BITS-1:0]            subtick_now_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fss_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fss_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fss_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import fss_pkg::*;

  localparam int unsigned COUNT_W = $clog2(MAX_FRAMES + 1);

  fss_cmd_t             cmd;
  fss_status_t          status;
  logic [TIME_BITS-1:0] tick_period;
  logic [COUNT_W-1:0]   frame_count;

  fss_regs #(
    .MAX_FRAMES (MAX_FRAMES),
    .TIME_BITS  (TIME_BITS)
  ) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .tick_period_o (tick_period),
    .frame_count_o (frame_count)
  );

  fss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fss_dp #(
    .MAX_FRAMES  (MAX_FRAMES),
    .LENGTH_BITS (LENGTH_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .tick_period_i  (tick_period),
    .frame_count_i  (frame_count),
    .req_type_i     (req_type_i),
    .elapsed_time_i (elapsed_time_i),
    .wrap_enable_i  (wrap_enable_i),
    .entry_index_i  (entry_index_i),
    .entry_length_i (entry_length_i),
    .finished_o     (finished_o),
    .frame_now_o    (frame_now_o),
    .subtick_now_o  (subtick_now_o)
  );

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench of frame_sequence_stepper_top
// a scoreboard class predicts finished, frame and sub-tick for every accepted word
// plain tasks drive the word and apb ports; depends on fss_pkg and the rtl

typedef struct packed {
  logic       fin;
  logic [3:0] frame;
  logic [7:0] sub;
} play_pos_t;

class frame_step_scoreboard;
  logic [15:0] tick_period;
  logic [4:0]  frame_count;
  logic [7:0]  lengths [16];
  int          acc;
  int          frame;
  int          sub;
  play_pos_t   pos_q [$];
  int unsigned n_words;
  int unsigned n_steps;
  int unsigned n_ends;
  int unsigned n_errors;

  function new();
    tick_period = 16'(fss_pkg::TICK_PERIOD_RESET);
    frame_count = 5'(fss_pkg::FRAME_COUNT_RESET);
    acc = 0;
    frame = 0;
    sub = 0;
    foreach (lengths[i]) lengths[i] = '0;
    n_words = 0;
    n_steps = 0;
    n_ends = 0;
    n_errors = 0;
  endfunction

  function void set_reg(logic idx, logic [31:0] value);
    if (idx == fss_pkg::REG_TICK_PERIOD) tick_period = value[15:0];
    else frame_count = value[4:0];
  endfunction

  function int eff_period();
    return (tick_period == 0) ? 1 : int'(tick_period);
  endfunction

  function int eff_count();
    if (frame_count == 0) return 1;
    if (frame_count > 16) return 16;
    return int'(frame_count);
  endfunction

  function int len_at(int f);
    return (f < 16) ? int'(lengths[f]) : 0;
  endfunction

  function int last_sub(int f);
    int l;
    l = len_at(f);
    return (l != 0) ? l - 1 : 0;
  endfunction

  function logic walk_forward(int elapsed, logic wrap);
    int   per;
    int   cnt;
    logic fin;
    per = eff_period();
    cnt = eff_count();
    fin = 1'b0;
    acc += elapsed;
    while (acc > per) begin
      sub++;
      if (sub > len_at(frame)) begin
        frame++;
        sub = 0;
        if (frame >= cnt) begin
          fin = 1'b1;
          if (wrap) begin
            frame = 0;
            sub = 0;
          end else begin
            frame = cnt - 1;
            sub = last_sub(frame);
            acc = per;
          end
        end
      end
      acc -= per;
    end
    return fin;
  endfunction

  function logic walk_backward(int elapsed, logic wrap);
    int   per;
    int   cnt;
    logic fin;
    per = eff_period();
    cnt = eff_count();
    fin = 1'b0;
    acc -= elapsed;
    while (acc < 0) begin
      if (sub != 0) begin
        sub--;
      end else if (frame == 0) begin
        fin = 1'b1;
        if (wrap) begin
          frame = cnt - 1;
          sub = last_sub(frame);
        end else begin
          frame = 0;
          sub = 0;
          acc = 0;
        end
      end else begin
        frame--;
        sub = len_at(frame);
      end
      acc += per;
    end
    return fin;
  endfunction

  function void note_word(logic [1:0] req, logic [15:0] elapsed, logic wrap,
                          logic [3:0] idx, logic [7:0] len);
    play_pos_t p;
    p.fin = 1'b0;
    case (req)
      fss_pkg::REQ_LOAD: lengths[idx] = len;
      fss_pkg::REQ_FWD: p.fin = walk_forward(int'(elapsed), wrap);
      fss_pkg::REQ_BWD: p.fin = walk_backward(int'(elapsed), wrap);
      default: ;
    endcase
    if (req == fss_pkg::REQ_FWD || req == fss_pkg::REQ_BWD) n_steps++;
    if (p.fin) n_ends++;
    p.frame = 4'(frame);
    p.sub = 8'(sub);
    pos_q.push_back(p);
  endfunction

  function void check_word(logic fin, logic [3:0] frame_o, logic [7:0] sub_o);
    play_pos_t exp_p;
    n_words++;
    if (pos_q.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("unexpected result word %0d: finished %0d frame %0d subtick %0d",
                 n_words, fin, frame_o, sub_o);
      return;
    end
    exp_p = pos_q.pop_front();
    if (exp_p.fin !== fin || exp_p.frame !== frame_o || exp_p.sub !== sub_o) begin
      n_errors++;
      if (n_errors <= 10)
        $display("result word %0d: expected finished %0d frame %0d subtick %0d, got %0d %0d %0d",
                 n_words, exp_p.fin, exp_p.frame, exp_p.sub, fin, frame_o, sub_o);
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0]  REQ_NONE = 2'd3;
  localparam int unsigned N_PHASES = 10;
  localparam int unsigned PHASE_WORDS = 200;
  localparam int unsigned PERIODS [N_PHASES] = '{1, 0, 65535, 40, 300, 7, 2048, 100, 13, 4000};
  localparam int unsigned COUNTS [N_PHASES] = '{16, 3, 16, 0, 31, 2, 5, 1, 8, 12};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [15:0] elapsed_time_i = '0;
  logic        wrap_enable_i = 1'b0;
  logic [3:0]  entry_index_i = '0;
  logic [7:0]  entry_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        finished_o;
  logic [3:0]  frame_now_o;
  logic [7:0]  subtick_now_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [fss_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [fss_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [fss_pkg::APB_DATA_W-1:0] prdata;
  logic        pready;

  frame_step_scoreboard sb;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned cycles = 0;
  int unsigned n_settings = 0;

  frame_sequence_stepper_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .elapsed_time_i (elapsed_time_i),
    .wrap_enable_i  (wrap_enable_i),
    .entry_index_i  (entry_index_i),
    .entry_length_i (entry_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .finished_o     (finished_o),
    .frame_now_o    (frame_now_o),
    .subtick_now_o  (subtick_now_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rcv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_word(req_type_i, elapsed_time_i, wrap_enable_i, entry_index_i, entry_length_i);
      if (out_valid_o && !out_stall_i)
        sb.check_word(finished_o, frame_now_o, subtick_now_o);
    end
  end

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pos_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_word(logic [1:0] req, logic [15:0] elapsed, logic wrap,
                           logic [3:0] idx, logic [7:0] len);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    elapsed_time_i <= elapsed;
    wrap_enable_i <= wrap;
    entry_index_i <= idx;
    entry_length_i <= len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    drain_results();
    repeat (2) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic send_random(int unsigned per);
    int unsigned r;
    int unsigned m;
    int unsigned e;
    logic [1:0]  req;
    logic [7:0]  len;
    r = $urandom_range(0, 99);
    len = 8'($urandom);
    if (r < 12) begin
      req = fss_pkg::REQ_LOAD;
      if ($urandom_range(0, 3) != 0) len = 8'($urandom_range(0, 4));
    end else if (r < 15) begin
      req = REQ_NONE;
    end else if (r < 57) begin
      req = fss_pkg::REQ_FWD;
    end else begin
      req = fss_pkg::REQ_BWD;
    end
    // keep the number of tick periods per step small
    if (per >= 2048 && $urandom_range(0, 9) == 0) begin
      e = $urandom & 32'hffff;
    end else begin
      m = $urandom_range(0, 24);
      e = per * m + $urandom_range(0, per - 1);
    end
    if (e > 65535) e = 65535;
    send_word(req, 16'(e), 1'($urandom), 4'($urandom), len);
  endtask

  initial begin
    int unsigned per;
    logic [7:0]  len;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    snd_idle = 23;
    rcv_idle = 69;

    // fill the whole length table before any step
    for (int i = 0; i < 16; i++) begin
      len = 8'($urandom_range(0, 3));
      if (i == 1) len = 8'h00;
      if (i == 2 || i == 15) len = 8'hff;
      send_word(fss_pkg::REQ_LOAD, 16'($urandom), 1'($urandom), 4'(i), len);
    end
    write_reg(fss_pkg::REG_FRAME_COUNT, 32'd2);
    n_settings++;
    send_word(fss_pkg::REQ_FWD, 16'h0000, 1'b0, 4'h0, 8'h00);
    send_word(fss_pkg::REQ_FWD, 16'hffff, 1'b1, 4'hf, 8'hff);
    send_word(fss_pkg::REQ_BWD, 16'hffff, 1'b0, 4'h0, 8'h00);
    send_word(fss_pkg::REQ_BWD, 16'd300, 1'b1, 4'h5, 8'h0f);
    send_word(fss_pkg::REQ_FWD, 16'hffff, 1'b0, 4'ha, 8'hf0);
    send_word(REQ_NONE, 16'($urandom), 1'($urandom), 4'($urandom), 8'($urandom));
    send_word(fss_pkg::REQ_BWD, 16'hffff, 1'b1, 4'h3, 8'h33);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 4) begin
        snd_idle = 69;
        rcv_idle = 23;
      end
      if (ph == 7) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      write_reg(fss_pkg::REG_TICK_PERIOD, PERIODS[ph]);
      write_reg(fss_pkg::REG_FRAME_COUNT, COUNTS[ph]);
      n_settings++;
      per = (PERIODS[ph] == 0) ? 1 : PERIODS[ph];
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        send_random(per);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("checked %0d result words from %0d steps, %0d of them reached a sequence end",
             sb.n_words, sb.n_steps, sb.n_ends);
    $display("%0d register settings, among them period 0 and frame counts 0, 1, 16 and 31",
             n_settings);
    if (sb.n_errors == 0 && sb.pos_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
